### rtl/aoc_pkg.sv
// Shared types, sizes and helpers for the box overlap counter.
package aoc_pkg;

  // Number of cells in the chain, one stored box each
  localparam int MaxBoxes = 256;
  // Per-set counter width; it must hold MaxBoxes itself
  localparam int CntW     = $clog2(MaxBoxes + 1);
  localparam int CoordW   = 32;
  localparam int SetHitsW = 9;
  localparam int TotalW   = 32;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
  } box_t;

  // One beat travelling down the chain
  typedef struct packed {
    logic            vld;     // beat present
    logic            last;    // final box of its set
    logic            placed;  // box already claimed a cell
    box_t            box;
    logic [CntW-1:0] cnt;     // hits gathered so far (used by the last beat)
  } aoc_tok_t;

  // Clamp the per-set count to the set_hits field
  function automatic logic [SetHitsW-1:0] sat_set_hits(input logic [CntW-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    if (wide > 32'd511) begin
      return 9'd511;
    end
    return SetHitsW'(wide);
  endfunction

endpackage

### rtl/aoc_cell.sv
// One chain cell: holds a stored box and its hit flag, compares each passing box.
module aoc_cell
  import aoc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  aoc_tok_t tok_i,
  output aoc_tok_t tok_o
);

  logic     occ_q, occ_d;
  logic     hit_q, hit_d;
  box_t     box_q;
  aoc_tok_t tok_q, tok_d;
  logic     touch;
  logic     hit_new;
  logic     take;

  // Compare the passing box against the stored one; edges touching count
  always_comb begin
    touch   = occ_q &&
              (box_q.min_x <= tok_i.box.max_x) && (box_q.max_x >= tok_i.box.min_x) &&
              (box_q.min_y <= tok_i.box.max_y) && (box_q.max_y >= tok_i.box.min_y);
    hit_new = hit_q | touch;
    take    = tok_i.vld && !occ_q && !tok_i.placed;
  end

  // Update the cell and the beat handed to the next cell
  always_comb begin
    occ_d = occ_q;
    hit_d = hit_q;
    tok_d = tok_i;
    if (tok_i.vld) begin
      if (occ_q) begin
        if (tok_i.last) begin
          tok_d.cnt = tok_i.cnt + CntW'(hit_new);
          occ_d     = 1'b0;
          hit_d     = 1'b0;
        end else begin
          hit_d = hit_new;
        end
      end else if (take) begin
        tok_d.placed = 1'b1;
        // a last box has nothing after it, so it never needs a cell
        occ_d        = !tok_i.last;
        hit_d        = 1'b0;
      end
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      hit_q <= 1'b0;
      tok_q <= '0;
    end else if (adv_i) begin
      occ_q <= occ_d;
      hit_q <= hit_d;
      tok_q <= tok_d;
    end
  end

  // Capture the box when this cell claims it
  always_ff @(posedge clk_i) begin
    if (adv_i && take) begin
      box_q <= tok_i.box;
    end
  end

  assign tok_o = tok_q;

endmodule

### rtl/aoc_tally.sv
// Chain tail: turns a last beat into a result and keeps the running total.
module aoc_tally
  import aoc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  aoc_tok_t            tok_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [SetHitsW-1:0] set_hits_o,
  output logic [TotalW-1:0]   total_hits_o
);

  logic                valid_q, valid_d;
  logic [SetHitsW-1:0] set_q, set_d;
  logic [TotalW-1:0]   total_q, total_d;
  logic [TotalW:0]     sum;
  logic                fire;

  // Add the set count into the saturating total
  always_comb begin
    fire    = adv_i && tok_i.vld && tok_i.last;
    set_d   = sat_set_hits(tok_i.cnt);
    sum     = {1'b0, total_q} + (TotalW + 1)'(set_d);
    total_d = total_q;
    valid_d = valid_q && out_stall_i;
    if (fire) begin
      total_d = sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];
      valid_d = 1'b1;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      total_q <= '0;
    end else begin
      valid_q <= valid_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      set_q <= set_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign set_hits_o   = set_q;
  assign total_hits_o = total_q;

endmodule

### rtl/aabb_overlap_counter_unit.sv
// Top level of the 2D box overlap counter: a chain of box cells and a tally stage.
//
//   channel | direction | handshake                | beat
//   in      | sink      | in_valid_i / in_stall_o  | min_x, min_y, max_x, max_y, last_box
//   out     | source    | out_valid_o / out_stall_i| set_hits, total_hits
//
// One box is taken per cycle while in_stall_o is low; each beat then walks the 256-cell
// chain one cell a cycle while the chain advances. A set's result appears once its last
// box has passed cell 0 (in its accept cycle), 255 more cells and the tally register.
// Reset clears every cell, the pipeline beats and the running total; no clearing pass.
// While a result waits under out_stall_i the whole chain holds and in_stall_o is high.
module aabb_overlap_counter_unit
  import aoc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [CoordW-1:0]  min_x_i,
  input  logic signed [CoordW-1:0]  min_y_i,
  input  logic signed [CoordW-1:0]  max_x_i,
  input  logic signed [CoordW-1:0]  max_y_i,
  input  logic                      last_box_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [SetHitsW-1:0]       set_hits_o,
  output logic [TotalW-1:0]         total_hits_o
);

  logic     adv;
  aoc_tok_t tok [MaxBoxes+1];

  // Freeze everything while a finished result is held
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Build the entry beat
  always_comb begin
    tok[0].vld       = in_valid_i;
    tok[0].last      = last_box_i;
    tok[0].placed    = 1'b0;
    tok[0].box.min_x = min_x_i;
    tok[0].box.min_y = min_y_i;
    tok[0].box.max_x = max_x_i;
    tok[0].box.max_y = max_y_i;
    tok[0].cnt       = '0;
  end

  // Chain of cells
  for (genvar g = 0; g < MaxBoxes; g++) begin : g_cell
    aoc_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  aoc_tally u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .tok_i       (tok[MaxBoxes]),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .set_hits_o  (set_hits_o),
    .total_hits_o(total_hits_o)
  );

  // A held result must stop the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while result is held");

  // The running total never falls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_hits_o >= $past(total_hits_o))
    else $error("running total decreased");

  // A set never reports more hits than cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((32'(set_hits_o) <= 32'(MaxBoxes)) || (set_hits_o == 9'd511)))
    else $error("set hit count out of range");

endmodule

### tb/sv/tb_aabb_overlap_counter_unit.sv
// Testbench for the box overlap counter: streams box sets and checks each set's hit tally.
`timescale 1ns / 100ps

module tb_aabb_overlap_counter_unit;
  import aoc_pkg::*;

  localparam int StallLimit    = 4000;  // cycles with no beat on either side
  localparam int RxHoldCycles  = 800;   // long receiver hold-off, beyond the chain latency
  localparam int DrainCycles   = 300;   // chain length plus tally, with margin
  localparam int BoxTarget     = 1300;
  localparam int SetHitsMax    = 511;
  localparam int Unit          = 65536; // 1.0 in Q16.16
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7fff_ffff;

  typedef struct {
    logic [SetHitsW-1:0] set_hits;
    logic [TotalW-1:0]   total_hits;
  } tally_t;

  // Track the boxes of the open set and predict the tally of each finished set
  class overlap_tally;
    box_t              cells[MaxBoxes];
    bit                hit[MaxBoxes];
    int                loaded;
    logic [TotalW-1:0] total;
    tally_t            pending[$];
    int                n_fail;

    function new();
      loaded = 0;
      total  = '0;
      n_fail = 0;
      foreach (hit[i]) hit[i] = 1'b0;
    endfunction

    // Update the open set with one accepted box beat
    function void take_box(box_t nb, logic is_last);
      int     count;
      tally_t t;
      logic [TotalW:0] sum;
      for (int i = 0; i < loaded; i++) begin
        if (!hit[i] &&
            $signed(cells[i].min_x) <= $signed(nb.max_x) &&
            $signed(cells[i].max_x) >= $signed(nb.min_x) &&
            $signed(cells[i].min_y) <= $signed(nb.max_y) &&
            $signed(cells[i].max_y) >= $signed(nb.min_y))
          hit[i] = 1'b1;
      end
      // Store only while a cell is free; later boxes compare but never count
      if (loaded < MaxBoxes) begin
        cells[loaded] = nb;
        hit[loaded]   = 1'b0;
        loaded++;
      end
      if (!is_last) return;
      count = 0;
      for (int i = 0; i < loaded; i++) if (hit[i]) count++;
      sum   = {1'b0, total} + (TotalW + 1)'(count);
      total = sum[TotalW] ? '1 : sum[TotalW-1:0];
      t.set_hits   = (count > SetHitsMax) ? SetHitsW'(SetHitsMax) : SetHitsW'(count);
      t.total_hits = total;
      pending.push_back(t);
      foreach (hit[i]) hit[i] = 1'b0;
      loaded = 0;
    endfunction

    // Compare one result beat with the oldest predicted tally
    function void check_tally(logic [SetHitsW-1:0] sh, logic [TotalW-1:0] th);
      tally_t t;
      if (pending.size() == 0) begin
        $error("result beat with no set pending: set_hits %0d, total_hits %0d", sh, th);
        n_fail++;
        return;
      end
      t = pending.pop_front();
      if (sh !== t.set_hits) begin
        $error("set_hits: expected %0d, got %0d", t.set_hits, sh);
        n_fail++;
      end
      if (th !== t.total_hits) begin
        $error("total_hits: expected %0d, got %0d", t.total_hits, th);
        n_fail++;
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  box_t                drv_box   = '0;
  logic                drv_last  = 1'b0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [SetHitsW-1:0] set_hits;
  logic [TotalW-1:0]   total_hits;

  overlap_tally tally = new();
  bit           quiet   = 1'b0;
  bit           hold_rx = 1'b0;
  int           n_boxes_sent = 0;
  int           idle_cycles  = 0;

  aabb_overlap_counter_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .min_x_i      (drv_box.min_x),
    .min_y_i      (drv_box.min_y),
    .max_x_i      (drv_box.max_x),
    .max_y_i      (drv_box.max_y),
    .last_box_i   (drv_last),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .set_hits_o   (set_hits),
    .total_hits_o (total_hits)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Note accepted boxes, check accepted results, and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tally.take_box(drv_box, drv_last);
      if (out_valid && !out_stall) tally.check_tally(set_hits, total_hits);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Mostly short gaps, now and then a long one, none in quiet stretches
  function automatic int idle_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic box_t mk(logic signed [CoordW-1:0] lx, logic signed [CoordW-1:0] ly,
                              logic signed [CoordW-1:0] hx, logic signed [CoordW-1:0] hy);
    box_t b;
    b.min_x = lx;
    b.min_y = ly;
    b.max_x = hx;
    b.max_y = hy;
    return b;
  endfunction

  function automatic logic signed [CoordW-1:0] edge_coord();
    case ($urandom_range(0, 3))
      0:       return CoordMin;
      1:       return CoordMax;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Dense boxes near the origin so sets see many overlaps, plus full-range noise
  function automatic box_t rand_box();
    int                        r;
    logic signed [CoordW-1:0]  x0, y0, wx, wy;
    r = $urandom_range(0, 99);
    if (r < 12) return mk($urandom, $urandom, $urandom, $urandom);
    if (r < 20) return mk(edge_coord(), edge_coord(), edge_coord(), edge_coord());
    if ($urandom_range(0, 1)) begin
      // whole-unit grid, so edges touch exactly
      x0 = ($signed($urandom_range(0, 20)) - 10) * Unit;
      y0 = ($signed($urandom_range(0, 20)) - 10) * Unit;
      wx = $urandom_range(0, 4) * Unit;
      wy = $urandom_range(0, 4) * Unit;
    end else begin
      x0 = $signed($urandom_range(0, 20 * Unit)) - 10 * Unit;
      y0 = $signed($urandom_range(0, 20 * Unit)) - 10 * Unit;
      wx = $urandom_range(0, 4 * Unit);
      wy = $urandom_range(0, 4 * Unit);
    end
    // turn some inside out
    if (r < 30) return mk(x0 + wx, y0 + wy, x0, y0);
    return mk(x0, y0, x0 + wx, y0 + wy);
  endfunction

  // Offer one box beat and hold it until taken
  task automatic send_box(input box_t b, input logic is_last);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    drv_box  <= b;
    drv_last <= is_last;
    do @(posedge clk); while (in_stall);
    n_boxes_sent++;
  endtask

  task automatic send_set(input int n_boxes);
    for (int i = 0; i < n_boxes; i++) send_box(rand_box(), i == n_boxes - 1);
  endtask

  task automatic run_directed();
    // widest box, alone in its set
    send_box(mk(CoordMin, CoordMin, CoordMax, CoordMax), 1'b1);
    // corner touch, edge touch, second hit on a flagged box, clear miss
    send_box(mk(0, 0, Unit, Unit), 1'b0);
    send_box(mk(Unit, Unit, 2 * Unit, 2 * Unit), 1'b0);
    send_box(mk(2 * Unit, Unit, 3 * Unit, Unit), 1'b0);
    send_box(mk(0, 0, Unit / 2, Unit / 2), 1'b0);
    send_box(mk(10 * Unit, 10 * Unit, 11 * Unit, 11 * Unit), 1'b1);
    // inside-out boxes against the widest box
    send_box(mk(5 * Unit, 5 * Unit, -5 * Unit, -5 * Unit), 1'b0);
    send_box(mk(CoordMin, CoordMin, CoordMax, CoordMax), 1'b0);
    send_box(mk(CoordMax, CoordMax, CoordMin, CoordMin), 1'b1);
    // miss by one LSB on each axis, then a touch at the negative corner
    send_box(mk(0, 0, Unit, Unit), 1'b0);
    send_box(mk(Unit + 1, 0, 2 * Unit, Unit), 1'b0);
    send_box(mk(0, Unit + 1, Unit, 2 * Unit), 1'b0);
    send_box(mk(-Unit, -Unit, -1, -1), 1'b0);
    send_box(mk(-1, -1, -1, -1), 1'b1);
    // alternating bit patterns
    send_box(mk(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA), 1'b0);
    send_box(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555), 1'b1);
  endtask

  // Result side: ready runs, random stalls, and one long hold-off on request
  initial begin : rx_side
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (RxHoldCycles) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        gap = idle_gap();
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Box side: directed sets, a back-pressure burst, then random sets
  initial begin : tx_side
    bit full_done, exact_done;
    int r;
    full_done  = 1'b0;
    exact_done = 1'b0;
    while (!rst_n) @(posedge clk);
    @(posedge clk);
    run_directed();

    // hold the result side while boxes keep coming, so the chain fills
    hold_rx = 1'b1;
    quiet   = 1'b1;
    repeat (25) send_set($urandom_range(2, 10));
    quiet   = 1'b0;

    while (n_boxes_sent < BoxTarget) begin
      quiet = ($urandom_range(0, 99) < 15);
      if (!full_done && n_boxes_sent > 450) begin
        // overflow the store: trailing boxes compare but are not kept
        send_set(MaxBoxes + 44);
        full_done = 1'b1;
      end else if (!exact_done && n_boxes_sent > 900) begin
        send_set(MaxBoxes);
        exact_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        send_set(r < 80 ? $urandom_range(1, 8) : $urandom_range(9, 40));
      end
    end
    quiet    = 1'b0;
    in_valid <= 1'b0;

    // drain the chain, then allow for any stray beat
    while (tally.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (tally.n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/aoc_pkg.sv
rtl/aoc_cell.sv
rtl/aoc_tally.sv
rtl/aabb_overlap_counter_unit.sv
tb/sv/tb_aabb_overlap_counter_unit.sv
